[src/bfr_pkg.sv]
// Shared types, widths and coefficient tables for the barrier factor ratio block.
package bfr_pkg;

    localparam int MAX_WAVES = 6;
    localparam int WAVE_IW   = 3;
    localparam int ORDER_W   = 3;
    localparam int Q_W       = 20;
    localparam int RADIUS_W  = 16;
    localparam int P_W       = Q_W + RADIUS_W;
    localparam int HI_W      = P_W - 20;
    localparam int LO_W      = 20;
    localparam int Z_W       = 32;
    localparam int LIMB_W    = 32;
    localparam int NLIMB     = 6;
    localparam int PV_W      = NLIMB * LIMB_W;
    localparam int SUM_W     = PV_W + LIMB_W;
    localparam int NSTEP     = 5;
    localparam int RATIO_W   = 24;
    localparam int CMP_W     = PV_W + 2 * RATIO_W + 2;
    localparam int CFG_IW    = 4;
    localparam int CFG_DW    = 16;
    localparam int COEF_W    = 20;

    typedef enum logic [CFG_IW-1:0] {
        REG_RADIUS     = CFG_IW'(0),
        REG_WAVE_COUNT = CFG_IW'(1),
        REG_ORDER_0    = CFG_IW'(2),
        REG_ORDER_1    = CFG_IW'(3),
        REG_ORDER_2    = CFG_IW'(4),
        REG_ORDER_3    = CFG_IW'(5),
        REG_ORDER_4    = CFG_IW'(6),
        REG_ORDER_5    = CFG_IW'(7)
    } t_cfg_reg;

    typedef struct packed {
        logic [WAVE_IW-1:0] wave_index;
        logic               last;
        logic [ORDER_W-1:0] order;
    } t_tag;

    localparam logic [COEF_W-1:0] POLY_COEF [6][5] = '{
        '{20'd0,  20'd0,   20'd0,    20'd0,     20'd0},
        '{20'd1,  20'd0,   20'd0,    20'd0,     20'd0},
        '{20'd3,  20'd9,   20'd0,    20'd0,     20'd0},
        '{20'd6,  20'd45,  20'd225,  20'd0,     20'd0},
        '{20'd10, 20'd135, 20'd1575, 20'd11025, 20'd0},
        '{20'd15, 20'd315, 20'd6300, 20'd99225, 20'd893025}
    };

    localparam logic [ORDER_W-1:0] MAX_ORDER = ORDER_W'(NSTEP);

    // orders above five behave as order zero (P = 1)
    function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] order);
        return (order > MAX_ORDER) ? '0 : order;
    endfunction

    // Horner step is live once step + order reaches the step count
    function automatic logic poly_active(input logic [ORDER_W-1:0] order,
                                         input logic [2:0] step);
        logic [3:0] sum;
        sum = {1'b0, step} + {1'b0, eff_order(order)};
        return sum >= 4'(NSTEP);
    endfunction

    function automatic logic [PV_W-1:0] poly_term(input logic [ORDER_W-1:0] order,
                                                  input logic [2:0] step);
        logic [ORDER_W-1:0] l;
        logic [3:0]         sum;
        logic [2:0]         j;
        logic [PV_W-1:0]    coef;
        l    = eff_order(order);
        sum  = {1'b0, step} + {1'b0, l};
        j    = (sum >= 4'(NSTEP)) ? 3'(sum - 4'(NSTEP)) : 3'd0;
        coef = PV_W'(POLY_COEF[l][j]);
        return (sum >= 4'(NSTEP)) ? (coef << {j + 3'd1, 4'b0000}) : '0;
    endfunction

endpackage

[src/bfr_if.sv]
// Handshake channel interfaces: momentum input, ratio output, register writes.
interface bfr_in_if import bfr_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [Q_W-1:0] momentum;
    logic [Q_W-1:0] reference_momentum;

    modport source (output valid, momentum, reference_momentum, input ready);
    modport sink   (input valid, momentum, reference_momentum, output ready);
endinterface

interface bfr_out_if import bfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RATIO_W-1:0] barrier_ratio;
    logic [WAVE_IW-1:0] wave_index;
    logic               last_in_run;

    modport source (output valid, barrier_ratio, wave_index, last_in_run, input ready);
    modport sink   (input valid, barrier_ratio, wave_index, last_in_run, output ready);
endinterface

interface bfr_cfg_if import bfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/bfr_horner_step.sv]
// One Horner step of both polynomials: limb products, then sum plus coefficient.
module bfr_horner_step import bfr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [2:0]      i_step,
    input  logic            i_valid,
    input  t_tag            i_tag,
    input  logic [Z_W-1:0]  i_z,
    input  logic [Z_W-1:0]  i_z0,
    input  logic [PV_W-1:0] i_num,
    input  logic [PV_W-1:0] i_den,
    output logic            o_valid,
    output t_tag            o_tag,
    output logic [Z_W-1:0]  o_z,
    output logic [Z_W-1:0]  o_z0,
    output logic [PV_W-1:0] o_num,
    output logic [PV_W-1:0] o_den
);

    logic                     r_a_v;
    t_tag                     r_a_tag;
    logic [Z_W-1:0]           r_a_z;
    logic [Z_W-1:0]           r_a_z0;
    logic [PV_W-1:0]          r_a_num;
    logic [PV_W-1:0]          r_a_den;
    logic                     r_a_act;
    logic [PV_W-1:0]          r_a_term;
    logic [2*LIMB_W-1:0]      r_a_pn [NLIMB];
    logic [2*LIMB_W-1:0]      r_a_pd [NLIMB];

    logic                     r_b_v;
    t_tag                     r_b_tag;
    logic [Z_W-1:0]           r_b_z;
    logic [Z_W-1:0]           r_b_z0;
    logic [PV_W-1:0]          r_b_num;
    logic [PV_W-1:0]          r_b_den;

    logic [SUM_W-1:0]         ev_n, od_n, ev_d, od_d;
    logic [PV_W-1:0]          n_num, n_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_tag  <= i_tag;
            r_a_z    <= i_z;
            r_a_z0   <= i_z0;
            r_a_num  <= i_num;
            r_a_den  <= i_den;
            r_a_act  <= poly_active(i_tag.order, i_step);
            r_a_term <= poly_term(i_tag.order, i_step);
            for (int i = 0; i < NLIMB; i++) begin
                r_a_pn[i] <= (2*LIMB_W)'(i_num[LIMB_W*i +: LIMB_W]) * (2*LIMB_W)'(i_z0);
                r_a_pd[i] <= (2*LIMB_W)'(i_den[LIMB_W*i +: LIMB_W]) * (2*LIMB_W)'(i_z);
            end
        end
    end

    // even and odd limb products do not overlap within their own vector
    always_comb begin
        ev_n = '0;
        od_n = '0;
        ev_d = '0;
        od_d = '0;
        for (int i = 0; i < NLIMB; i++) begin
            if (i % 2 == 0) begin
                ev_n[LIMB_W*i +: 2*LIMB_W] = r_a_pn[i];
                ev_d[LIMB_W*i +: 2*LIMB_W] = r_a_pd[i];
            end else begin
                od_n[LIMB_W*i +: 2*LIMB_W] = r_a_pn[i];
                od_d[LIMB_W*i +: 2*LIMB_W] = r_a_pd[i];
            end
        end
        n_num = r_a_act ? PV_W'(ev_n + od_n + SUM_W'(r_a_term)) : r_a_num;
        n_den = r_a_act ? PV_W'(ev_d + od_d + SUM_W'(r_a_term)) : r_a_den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_tag <= r_a_tag;
            r_b_z   <= r_a_z;
            r_b_z0  <= r_a_z0;
            r_b_num <= n_num;
            r_b_den <= n_den;
        end
    end

    assign o_valid = r_b_v;
    assign o_tag   = r_b_tag;
    assign o_z     = r_b_z;
    assign o_z0    = r_b_z0;
    assign o_num   = r_b_num;
    assign o_den   = r_b_den;

endmodule

[src/bfr_root_step.sv]
// One bit of the ratio square root: trial against the running remainder.
module bfr_root_step import bfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [4:0]         i_bit,
    input  logic               i_valid,
    input  t_tag               i_tag,
    input  logic [PV_W-1:0]    i_den,
    input  logic [CMP_W-1:0]   i_rem,
    input  logic [CMP_W-1:0]   i_acc,
    input  logic [RATIO_W-1:0] i_root,
    output logic               o_valid,
    output t_tag               o_tag,
    output logic [PV_W-1:0]    o_den,
    output logic [CMP_W-1:0]   o_rem,
    output logic [CMP_W-1:0]   o_acc,
    output logic [RATIO_W-1:0] o_root
);

    logic                r_v;
    t_tag                r_tag;
    logic [PV_W-1:0]     r_den;
    logic [CMP_W-1:0]    r_rem;
    logic [CMP_W-1:0]    r_acc;
    logic [RATIO_W-1:0]  r_root;

    logic [CMP_W-1:0]    inc;
    logic                take;
    logic [CMP_W-1:0]    n_rem;
    logic [CMP_W-1:0]    n_acc;
    logic [RATIO_W-1:0]  n_root;

    // (r + 2^b)^2 den - r^2 den = r den 2^(b+1) + den 2^(2b); acc holds r den
    always_comb begin
        inc    = (i_acc << ({1'b0, i_bit} + 6'd1)) + (CMP_W'(i_den) << {i_bit, 1'b0});
        take   = inc <= i_rem;
        n_rem  = take ? i_rem - inc : i_rem;
        n_acc  = take ? i_acc + (CMP_W'(i_den) << i_bit) : i_acc;
        n_root = i_root | (RATIO_W'(take) << i_bit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag  <= i_tag;
            r_den  <= i_den;
            r_rem  <= n_rem;
            r_acc  <= n_acc;
            r_root <= n_root;
        end
    end

    assign o_valid = r_v;
    assign o_tag   = r_tag;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_acc   = r_acc;
    assign o_root  = r_root;

endmodule

[src/barrier_factor_ratio.sv]
// Top level: Blatt-Weisskopf barrier factor ratio, one result per configured wave.
//
// Channels: i_in takes a momentum pair (q, q0), o_out gives one word per configured
// wave with the wave index and a last marker, i_cfg writes the radius, wave count
// and wave orders (always ready; write only while the block is idle).
// Each accepted pair is expanded into one wave per cycle while the pipeline is
// not held, so a pair holds the input until its waves (1 to 6) are issued; a
// new pair is taken in the cycle its predecessor issues its final wave.
// Each wave flows through a pipeline: 3 stages for z and z0, two per
// Horner step over 5 steps for both polynomials, one per bit for the 24-bit
// square root, then the output register. Words leave at one word per cycle
// while the pipeline is not held.
// Reset clears all valid bits and sets radius 3.0, wave count 1, orders 0.
// When the receiver stalls, a skid stage catches the word in flight; the pipeline
// then holds and the input drops ready until the skid empties.
module barrier_factor_ratio import bfr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bfr_in_if.sink       i_in,
    bfr_out_if.source    o_out,
    bfr_cfg_if.sink      i_cfg
);

    logic [RADIUS_W-1:0]  r_radius;
    logic [WAVE_IW-1:0]   r_wave_count;
    logic [ORDER_W-1:0]   r_order [MAX_WAVES];

    logic                 r_hold_v;
    logic [Q_W-1:0]       r_q;
    logic [Q_W-1:0]       r_q0;
    logic [WAVE_IW-1:0]   r_k;

    logic                 en;
    logic [WAVE_IW-1:0]   n_waves;
    logic                 emit_last;
    logic                 in_take;
    t_tag                 emit_tag;

    logic                 r_s1_v, r_s2_v, r_s3_v;
    t_tag                 r_s1_tag, r_s2_tag, r_s3_tag;
    logic [P_W-1:0]       r_s1_p, r_s1_p0;
    logic [2*HI_W-1:0]    r_s2_hh, r_s2_hh0;
    logic [HI_W+LO_W-1:0] r_s2_hl, r_s2_hl0;
    logic [2*LO_W-1:0]    r_s2_ll, r_s2_ll0;
    logic [Z_W-1:0]       r_s3_z, r_s3_z0;
    logic [Z_W-1:0]       n_z, n_z0;

    logic                 h_v   [NSTEP+1];
    t_tag                 h_tag [NSTEP+1];
    logic [Z_W-1:0]       h_z   [NSTEP+1];
    logic [Z_W-1:0]       h_z0  [NSTEP+1];
    logic [PV_W-1:0]      h_num [NSTEP+1];
    logic [PV_W-1:0]      h_den [NSTEP+1];

    logic                 rt_v    [RATIO_W+1];
    t_tag                 rt_tag  [RATIO_W+1];
    logic [PV_W-1:0]      rt_den  [RATIO_W+1];
    logic [CMP_W-1:0]     rt_rem  [RATIO_W+1];
    logic [CMP_W-1:0]     rt_acc  [RATIO_W+1];
    logic [RATIO_W-1:0]   rt_root [RATIO_W+1];

    logic                 r_out_v, r_skid_v;
    logic [RATIO_W-1:0]   r_out_ratio, r_skid_ratio;
    t_tag                 r_out_tag, r_skid_tag;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= RADIUS_W'(12288);
            r_wave_count <= WAVE_IW'(1);
            for (int i = 0; i < MAX_WAVES; i++) begin
                r_order[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_RADIUS:     r_radius     <= i_cfg.data;
                REG_WAVE_COUNT: r_wave_count <= i_cfg.data[WAVE_IW-1:0];
                REG_ORDER_0:    r_order[0]   <= i_cfg.data[ORDER_W-1:0];
                REG_ORDER_1:    r_order[1]   <= i_cfg.data[ORDER_W-1:0];
                REG_ORDER_2:    r_order[2]   <= i_cfg.data[ORDER_W-1:0];
                REG_ORDER_3:    r_order[3]   <= i_cfg.data[ORDER_W-1:0];
                REG_ORDER_4:    r_order[4]   <= i_cfg.data[ORDER_W-1:0];
                REG_ORDER_5:    r_order[5]   <= i_cfg.data[ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    // wave expansion
    assign en = !r_skid_v;

    always_comb begin
        if (r_wave_count == '0) begin
            n_waves = WAVE_IW'(1);
        end else if (r_wave_count > WAVE_IW'(MAX_WAVES)) begin
            n_waves = WAVE_IW'(MAX_WAVES);
        end else begin
            n_waves = r_wave_count;
        end
        emit_last           = r_k == n_waves - WAVE_IW'(1);
        emit_tag.wave_index = r_k;
        emit_tag.last       = emit_last;
        emit_tag.order      = r_order[r_k];
    end

    assign i_in.ready = en && (!r_hold_v || emit_last);
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_k      <= '0;
        end else if (en) begin
            if (in_take) begin
                r_hold_v <= 1'b1;
                r_k      <= '0;
            end else if (r_hold_v) begin
                r_hold_v <= !emit_last;
                r_k      <= emit_last ? '0 : r_k + WAVE_IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_q  <= i_in.momentum;
            r_q0 <= i_in.reference_momentum;
        end
    end

    // z = floor((q d)^2 / 2^40), split into 16-bit high and 20-bit low halves
    always_comb begin
        n_z  = Z_W'(Z_W'(r_s2_hh)
             + Z_W'((({r_s2_hl, 21'b0} + (HI_W+LO_W+21)'(r_s2_ll))) >> 40));
        n_z0 = Z_W'(Z_W'(r_s2_hh0)
             + Z_W'((({r_s2_hl0, 21'b0} + (HI_W+LO_W+21)'(r_s2_ll0))) >> 40));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= r_hold_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_tag <= emit_tag;
            r_s1_p   <= P_W'(r_q)  * P_W'(r_radius);
            r_s1_p0  <= P_W'(r_q0) * P_W'(r_radius);
            r_s2_tag <= r_s1_tag;
            r_s2_hh  <= (2*HI_W)'(r_s1_p[P_W-1:LO_W]) * (2*HI_W)'(r_s1_p[P_W-1:LO_W]);
            r_s2_hh0 <= (2*HI_W)'(r_s1_p0[P_W-1:LO_W]) * (2*HI_W)'(r_s1_p0[P_W-1:LO_W]);
            r_s2_hl  <= (HI_W+LO_W)'(r_s1_p[P_W-1:LO_W]) * (HI_W+LO_W)'(r_s1_p[LO_W-1:0]);
            r_s2_hl0 <= (HI_W+LO_W)'(r_s1_p0[P_W-1:LO_W]) * (HI_W+LO_W)'(r_s1_p0[LO_W-1:0]);
            r_s2_ll  <= (2*LO_W)'(r_s1_p[LO_W-1:0]) * (2*LO_W)'(r_s1_p[LO_W-1:0]);
            r_s2_ll0 <= (2*LO_W)'(r_s1_p0[LO_W-1:0]) * (2*LO_W)'(r_s1_p0[LO_W-1:0]);
            r_s3_tag <= r_s2_tag;
            r_s3_z   <= n_z;
            r_s3_z0  <= n_z0;
        end
    end

    // polynomials, scaled by 2^(16 l), start at one
    assign h_v[0]   = r_s3_v;
    assign h_tag[0] = r_s3_tag;
    assign h_z[0]   = r_s3_z;
    assign h_z0[0]  = r_s3_z0;
    assign h_num[0] = PV_W'(1);
    assign h_den[0] = PV_W'(1);

    for (genvar g = 0; g < NSTEP; g++) begin : g_horner
        bfr_horner_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (3'(g)),
            .i_valid (h_v[g]),
            .i_tag   (h_tag[g]),
            .i_z     (h_z[g]),
            .i_z0    (h_z0[g]),
            .i_num   (h_num[g]),
            .i_den   (h_den[g]),
            .o_valid (h_v[g+1]),
            .o_tag   (h_tag[g+1]),
            .o_z     (h_z[g+1]),
            .o_z0    (h_z0[g+1]),
            .o_num   (h_num[g+1]),
            .o_den   (h_den[g+1])
        );
    end

    // largest R with R^2 P(z) <= 2^32 P(z0)
    assign rt_v[0]    = h_v[NSTEP];
    assign rt_tag[0]  = h_tag[NSTEP];
    assign rt_den[0]  = h_den[NSTEP];
    assign rt_rem[0]  = CMP_W'(h_num[NSTEP]) << Z_W;
    assign rt_acc[0]  = '0;
    assign rt_root[0] = '0;

    for (genvar g = 0; g < RATIO_W; g++) begin : g_root
        bfr_root_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bit   (5'(RATIO_W - 1 - g)),
            .i_valid (rt_v[g]),
            .i_tag   (rt_tag[g]),
            .i_den   (rt_den[g]),
            .i_rem   (rt_rem[g]),
            .i_acc   (rt_acc[g]),
            .i_root  (rt_root[g]),
            .o_valid (rt_v[g+1]),
            .o_tag   (rt_tag[g+1]),
            .o_den   (rt_den[g+1]),
            .o_rem   (rt_rem[g+1]),
            .o_acc   (rt_acc[g+1]),
            .o_root  (rt_root[g+1])
        );
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_out.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || o_out.ready) begin
            r_out_v <= rt_v[RATIO_W];
        end else if (rt_v[RATIO_W]) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (o_out.ready) begin
                r_out_ratio <= r_skid_ratio;
                r_out_tag   <= r_skid_tag;
            end
        end else if (!r_out_v || o_out.ready) begin
            r_out_ratio <= rt_root[RATIO_W];
            r_out_tag   <= rt_tag[RATIO_W];
        end else begin
            r_skid_ratio <= rt_root[RATIO_W];
            r_skid_tag   <= rt_tag[RATIO_W];
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.barrier_ratio = r_out_ratio;
    assign o_out.wave_index    = r_out_tag.wave_index;
    assign o_out.last_in_run   = r_out_tag.last;

endmodule

[src/bfr_checker.sv]
// Port-level checks on the result channel, bound to the top level.
module bfr_checker import bfr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [RATIO_W-1:0] i_ratio,
    input logic [WAVE_IW-1:0] i_index,
    input logic               i_last
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_ratio) && $stable(i_index)
            && $stable(i_last))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_index <= WAVE_IW'(MAX_WAVES - 1))
        else $error("wave index beyond wave limit");

    a_final_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_index == WAVE_IW'(MAX_WAVES - 1) |-> i_last)
        else $error("final wave not marked last");

endmodule

bind barrier_factor_ratio bfr_checker u_bfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_ratio     (o_out.barrier_ratio),
    .i_index     (o_out.wave_index),
    .i_last      (o_out.last_in_run)
);
